// File: rtl/core/i2crm_pkg.sv
// Shared types, codes and the segment plan for the register-access I2C master.
// Used by i2crm_step and i2c_register_access_master_core.
package i2crm_pkg;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_READ  = 2'd2,
		ACT_PROBE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_IO_ERROR = 2'd1,
		ST_REJECTED = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_START    = 4'd1,
		PH_WRITE    = 4'd2,
		PH_WACK     = 4'd3,
		PH_READ_PRE = 4'd4,
		PH_READ     = 4'd5,
		PH_RACK     = 4'd6,
		PH_STOP     = 4'd7,
		PH_CLR_INIT = 4'd8,
		PH_CLR_LOW  = 4'd9,
		PH_CLR_HIGH = 4'd10,
		PH_CLR_SDA0 = 4'd11,
		PH_CLR_SCL1 = 4'd12,
		PH_CLR_SDA1 = 4'd13,
		PH_WAIT     = 4'd14
	} phase_t;

	typedef enum logic [2:0] {
		K_START = 3'd0,
		K_WADDR = 3'd1,
		K_WREG  = 3'd2,
		K_WVAL  = 3'd3,
		K_RADDR = 3'd4,
		K_READ  = 3'd5,
		K_STOP  = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		CFG_RETRY_LIMIT  = 2'd0,
		CFG_CLEAR_PULSES = 2'd1,
		CFG_CLEAR_HALF   = 2'd2,
		CFG_RETRY_WAIT   = 2'd3
	} cfg_index_t;

	localparam logic [3:0]  RETRY_LIMIT_RST  = 4'd5;
	localparam logic [3:0]  CLEAR_PULSES_RST = 4'd9;
	localparam logic [7:0]  CLEAR_HALF_RST   = 8'd50;
	localparam logic [15:0] RETRY_WAIT_RST   = 16'd250;
	localparam logic [3:0]  ATTEMPT_MAX      = 4'd15;
	localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;

	typedef struct packed {
		logic [3:0]  retry_limit;
		logic [3:0]  clear_pulse_count;
		logic [7:0]  clear_half_ticks;
		logic [15:0] retry_wait_ticks;
	} cfg_t;

	typedef struct packed {
		action_t    action;
		logic [6:0] device_address;
		logic [7:0] register_address;
		logic [7:0] write_value;
		logic       sda_sampled;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		status_t    status;
		logic [7:0] read_data;
		logic [15:0] recovery_count;
	} res_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  sub;
		logic [3:0]  bit_index;
		logic [7:0]  shift_byte;
		action_t     held_action;
		logic [6:0]  held_device_address;
		logic [7:0]  held_register_address;
		logic [7:0]  held_write_value;
		logic [3:0]  attempt_count;
		logic [15:0] wait_counter;
		logic [3:0]  pulse_counter;
		logic [15:0] recoveries;
		logic [7:0]  received_byte;
		logic [2:0]  seg;
		logic        nack_seen;
		logic        scl_drive;
		logic        sda_drive;
		status_t     last_status;
	} state_t;

	// Idle with both lines released.
	localparam state_t STATE_RST = '{
		phase: PH_IDLE,
		sub: 2'd0,
		bit_index: 4'd0,
		shift_byte: 8'd0,
		held_action: ACT_TICK,
		held_device_address: 7'd0,
		held_register_address: 8'd0,
		held_write_value: 8'd0,
		attempt_count: 4'd0,
		wait_counter: 16'd0,
		pulse_counter: 4'd0,
		recoveries: 16'd0,
		received_byte: 8'd0,
		seg: 3'd0,
		nack_seen: 1'b0,
		scl_drive: 1'b1,
		sda_drive: 1'b1,
		last_status: ST_OK
	};

	// Segment sequence of each command; an unknown action runs as a probe.
	function automatic kind_t plan_kind(action_t a, logic [2:0] seg);
		kind_t k;
		k = K_STOP;
		case (a)
			ACT_WRITE: begin
				case (seg)
					3'd0:    k = K_START;
					3'd1:    k = K_WADDR;
					3'd2:    k = K_WREG;
					3'd3:    k = K_WVAL;
					default: k = K_STOP;
				endcase
			end
			ACT_READ: begin
				case (seg)
					3'd0:    k = K_START;
					3'd1:    k = K_WADDR;
					3'd2:    k = K_WREG;
					3'd3:    k = K_START;
					3'd4:    k = K_RADDR;
					3'd5:    k = K_READ;
					default: k = K_STOP;
				endcase
			end
			default: begin
				case (seg)
					3'd0:    k = K_START;
					3'd1:    k = K_WADDR;
					default: k = K_STOP;
				endcase
			end
		endcase
		return k;
	endfunction

endpackage

// File: rtl/core/i2c_register_access_master_core.sv
// Top level of the bit-banged register-access I2C master: handshakes,
// configuration registers, input, state and result registers. Depends on
// i2crm_pkg and i2crm_step.
//
// Usage: every item on the s_ channel is one bus half-period tick. s_tuser
// carries the action (tick only, write, read, probe); s_tdata carries the
// device address, register address, write value and the sampled SDA level.
// Every accepted item yields exactly one result item on the m_ channel with
// the SCL and SDA drive levels, busy, done, status, last read byte and the
// recovery count. A command given while busy is dropped and marks status 2.
// The result item passes through two registers: the input register takes
// the item, the state update between them is combinational, and the result
// register holds its result. One item is taken per cycle while the receiver
// does not stall. When the receiver stalls, the result register holds and
// the input register fills, then s_tready drops.
// Reset clears the lines to released, the state to idle and the registers
// to 5 attempts, 9 clear pulses, 50 ticks per half pulse, 250 wait ticks.
// The cfg channel is always ready; the user must write it only while idle, as the block itself does not enforce this.
module i2c_register_access_master_core import i2crm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [6:0] device_address, [14:7] register_address, [22:15] write_value,
	// [23] sda_sampled
	input  logic [23:0] s_tdata,
	// [1:0] action
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res, [5:4] status,
	// [13:6] read_data, [29:14] recovery_count, [31:30] zero
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t   cfg_q;
	item_t  item_s1;
	logic   valid_s1;
	state_t st_q;
	state_t st_next;
	res_t   res;
	res_t   res_s2;
	logic   valid_s2;
	logic   advance;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_limit <= RETRY_LIMIT_RST;
			cfg_q.clear_pulse_count <= CLEAR_PULSES_RST;
			cfg_q.clear_half_ticks <= CLEAR_HALF_RST;
			cfg_q.retry_wait_ticks <= RETRY_WAIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_RETRY_LIMIT:  cfg_q.retry_limit <= cfg_data[3:0];
				CFG_CLEAR_PULSES: cfg_q.clear_pulse_count <= cfg_data[3:0];
				CFG_CLEAR_HALF:   cfg_q.clear_half_ticks <= cfg_data[7:0];
				default:          cfg_q.retry_wait_ticks <= cfg_data;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action <= action_t'(s_tuser);
			item_s1.device_address <= s_tdata[6:0];
			item_s1.register_address <= s_tdata[14:7];
			item_s1.write_value <= s_tdata[22:15];
			item_s1.sda_sampled <= s_tdata[23];
		end
	end

	i2crm_step u_step (
		.st      (st_q),
		.item    (item_s1),
		.cfg     (cfg_q),
		.st_next (st_next),
		.res     (res)
	);

	// advance the bus state once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RST;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {2'b00, res_s2.recovery_count, res_s2.read_data, res_s2.status,
		res_s2.done_res, res_s2.busy_res, res_s2.sda_level, res_s2.scl_level};

endmodule

// File: rtl/core/i2crm_step.sv
// One bus half-step of the I2C master: next state and result from state and item.
// Depends on i2crm_pkg.
module i2crm_step import i2crm_pkg::*; (
	input  state_t st,
	input  item_t  item,
	input  cfg_t   cfg,
	output state_t st_next,
	output res_t   res
);

	logic rejected;
	logic done;

	function automatic state_t seg_begin(state_t s);
		state_t r;
		r = s;
		r.sub = 2'd0;
		r.bit_index = 4'd0;
		r.phase = PH_WRITE;
		case (plan_kind(s.held_action, s.seg))
			K_START: r.phase = PH_START;
			K_WADDR: r.shift_byte = {s.held_device_address, 1'b0};
			K_WREG:  r.shift_byte = s.held_register_address;
			K_WVAL:  r.shift_byte = s.held_write_value;
			K_RADDR: r.shift_byte = {s.held_device_address, 1'b1};
			K_READ: begin
				r.shift_byte = 8'd0;
				r.phase = PH_READ_PRE;
			end
			default: r.phase = PH_STOP;
		endcase
		return r;
	endfunction

	function automatic state_t seg_next(state_t s);
		state_t r;
		r = s;
		r.seg = 3'(s.seg + 3'd1);
		return seg_begin(r);
	endfunction

	function automatic state_t attempt_start(state_t s);
		state_t r;
		r = s;
		r.seg = 3'd0;
		r.nack_seen = 1'b0;
		return seg_begin(r);
	endfunction

	always_comb begin
		state_t n;
		logic [15:0] half;
		logic [15:0] cnt;
		logic        hold_ok;
		logic [3:0]  lim;
		logic        wait_end;

		n = st;
		rejected = 1'b0;
		done = 1'b0;
		half = (cfg.clear_half_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.clear_half_ticks};
		lim = (cfg.retry_limit == 4'd0) ? 4'd1 : cfg.retry_limit;

		if (item.action != ACT_TICK) begin
			if (st.phase != PH_IDLE) begin
				rejected = 1'b1;
			end else begin
				n.held_action = item.action;
				n.held_device_address = item.device_address;
				n.held_register_address = item.register_address;
				n.held_write_value = item.write_value;
				n.attempt_count = 4'd0;
				n.wait_counter = 16'd0;
				n = attempt_start(n);
			end
		end

		// bus-clear hold counter
		cnt = 16'(n.wait_counter + 16'd1);
		hold_ok = (cnt >= half);
		wait_end = 1'b0;

		case (n.phase)
			PH_START: begin
				case (n.sub)
					2'd0:    n.sda_drive = 1'b1;
					2'd1:    n.scl_drive = 1'b1;
					2'd2:    n.sda_drive = 1'b0;
					default: n.scl_drive = 1'b0;
				endcase
				if (n.sub == 2'd3) n = seg_next(n);
				else n.sub = 2'(n.sub + 2'd1);
			end
			PH_WRITE: begin
				if (n.sub == 2'd0) begin
					n.sda_drive = n.shift_byte[7];
					n.sub = 2'd1;
				end else if (n.sub == 2'd1) begin
					n.scl_drive = 1'b1;
					n.sub = 2'd2;
				end else begin
					n.scl_drive = 1'b0;
					n.shift_byte = {n.shift_byte[6:0], 1'b0};
					n.sub = 2'd0;
					n.bit_index = 4'(n.bit_index + 4'd1);
					if (n.bit_index >= BITS_PER_BYTE) begin
						n.bit_index = 4'd0;
						n.phase = PH_WACK;
					end
				end
			end
			PH_WACK: begin
				case (n.sub)
					2'd0:    n.sda_drive = 1'b1;
					2'd1:    n.scl_drive = 1'b1;
					2'd2:    n.nack_seen = item.sda_sampled;
					default: n.scl_drive = 1'b0;
				endcase
				if (n.sub == 2'd3) begin
					if (n.nack_seen) begin
						n.phase = PH_STOP;
						n.sub = 2'd0;
					end else begin
						n = seg_next(n);
					end
				end else begin
					n.sub = 2'(n.sub + 2'd1);
				end
			end
			PH_READ_PRE: begin
				n.sda_drive = 1'b1;
				n.phase = PH_READ;
				n.sub = 2'd0;
				n.bit_index = 4'd0;
			end
			PH_READ: begin
				if (n.sub == 2'd0) begin
					n.scl_drive = 1'b1;
					n.sub = 2'd1;
				end else if (n.sub == 2'd1) begin
					n.shift_byte = {n.shift_byte[6:0], item.sda_sampled};
					n.sub = 2'd2;
				end else begin
					n.scl_drive = 1'b0;
					n.sub = 2'd0;
					n.bit_index = 4'(n.bit_index + 4'd1);
					if (n.bit_index >= BITS_PER_BYTE) begin
						n.bit_index = 4'd0;
						n.phase = PH_RACK;
					end
				end
			end
			PH_RACK: begin
				case (n.sub)
					2'd0:    n.sda_drive = 1'b1;
					2'd1:    n.scl_drive = 1'b1;
					2'd2:    n.scl_drive = 1'b0;
					default: n.sda_drive = 1'b1;
				endcase
				if (n.sub == 2'd3) n = seg_next(n);
				else n.sub = 2'(n.sub + 2'd1);
			end
			PH_STOP: begin
				if (n.sub == 2'd0) begin
					n.sda_drive = 1'b0;
					n.sub = 2'd1;
				end else if (n.sub == 2'd1) begin
					n.scl_drive = 1'b1;
					n.sub = 2'd2;
				end else begin
					n.sda_drive = 1'b1;
					n.sub = 2'd0;
					if (n.nack_seen) begin
						n.recoveries = 16'(n.recoveries + 16'd1);
						n.phase = PH_CLR_INIT;
					end else begin
						if (n.held_action == ACT_READ) n.received_byte = n.shift_byte;
						n.phase = PH_IDLE;
						n.last_status = ST_OK;
						done = 1'b1;
					end
				end
			end
			PH_CLR_INIT: begin
				n.scl_drive = 1'b1;
				n.sda_drive = 1'b1;
				n.wait_counter = 16'd0;
				n.pulse_counter = 4'd0;
				n.phase = (cfg.clear_pulse_count != 4'd0) ? PH_CLR_LOW : PH_CLR_SDA0;
			end
			PH_CLR_LOW: begin
				n.scl_drive = 1'b0;
				n.wait_counter = hold_ok ? 16'd0 : cnt;
				if (hold_ok) n.phase = PH_CLR_HIGH;
			end
			PH_CLR_HIGH: begin
				n.scl_drive = 1'b1;
				n.wait_counter = hold_ok ? 16'd0 : cnt;
				if (hold_ok) begin
					n.pulse_counter = 4'(n.pulse_counter + 4'd1);
					n.phase = (n.pulse_counter >= cfg.clear_pulse_count) ?
						PH_CLR_SDA0 : PH_CLR_LOW;
				end
			end
			PH_CLR_SDA0: begin
				n.sda_drive = 1'b0;
				n.wait_counter = hold_ok ? 16'd0 : cnt;
				if (hold_ok) n.phase = PH_CLR_SCL1;
			end
			PH_CLR_SCL1: begin
				n.scl_drive = 1'b1;
				n.wait_counter = hold_ok ? 16'd0 : cnt;
				if (hold_ok) n.phase = PH_CLR_SDA1;
			end
			PH_CLR_SDA1: begin
				n.sda_drive = 1'b1;
				n.wait_counter = hold_ok ? 16'd0 : cnt;
				if (hold_ok) begin
					if (n.attempt_count < ATTEMPT_MAX) n.attempt_count = 4'(n.attempt_count + 4'd1);
					if (cfg.retry_wait_ticks == 16'd0) wait_end = 1'b1;
					else n.phase = PH_WAIT;
				end
			end
			PH_WAIT: begin
				n.wait_counter = cnt;
				if (cnt >= cfg.retry_wait_ticks) wait_end = 1'b1;
			end
			default: n.phase = PH_IDLE;
		endcase

		// end of retry wait: report io error or start the next attempt
		if (wait_end) begin
			n.wait_counter = 16'd0;
			if (n.attempt_count >= lim) begin
				n.phase = PH_IDLE;
				n.last_status = ST_IO_ERROR;
				done = 1'b1;
			end else begin
				n = attempt_start(n);
			end
		end

		st_next = n;
	end

	always_comb begin
		res.scl_level = st_next.scl_drive;
		res.sda_level = st_next.sda_drive;
		res.busy_res = (st_next.phase != PH_IDLE);
		res.done_res = done;
		res.status = rejected ? ST_REJECTED : st_next.last_status;
		res.read_data = st_next.received_byte;
		res.recovery_count = st_next.recoveries;
	end

endmodule

// File: rtl/core/i2crm_checker.sv
// Port-level checks of the I2C master's result stream, bound to the top level.
// Depends on i2c_register_access_master_core.
module i2crm_bus_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// a stalled result item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result item changed");

	// the padding above the recovery count stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:30] == 2'b00)
		else $error("padding bits set");

	// a finishing tick leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[2])
		else $error("done while busy");

	// an idle bus has both lines released
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[0] && m_tdata[1])
		else $error("line held low while idle");

endmodule

bind i2c_register_access_master_core i2crm_bus_checker u_i2crm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
